[hw/rtl/tsp_pkg.sv]
`timescale 1ns / 1ps

package tsp_pkg;

  localparam int unsigned DefaultTableDepth = 64;

  localparam int unsigned OpW       = 3;
  localparam int unsigned IndexW    = 6;
  localparam int unsigned FreqW     = 16;
  localparam int unsigned DurW      = 16;
  localparam int unsigned ClockW    = 30;
  localparam int unsigned PrescW    = 17;
  localparam int unsigned TickW     = 23;
  localparam int unsigned ReloadW   = 30;
  localparam int unsigned CompareW  = 29;
  localparam int unsigned EventW    = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 30;

  // tones are 100..8000 Hz, so 13 bits carry any frequency that reaches the divider
  localparam int unsigned ToneFreqW = 13;
  localparam logic [FreqW-1:0] FreqMin = 16'd100;
  localparam logic [FreqW-1:0] FreqMax = 16'd8000;
  localparam logic [ToneFreqW-1:0] SilenceFreq = 13'd100;

  // frequency / 100 as (f * 5243) >> 19, exact for f <= 8000
  localparam logic [ToneFreqW-1:0] HundRecip = 13'd5243;
  localparam int unsigned HundShift = 19;
  localparam int unsigned HundW     = 7;

  localparam logic [ClockW-1:0] ClockReset = 30'd64000000;
  localparam logic [PrescW-1:0] PrescReset = 17'd64;

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_PLAY    = 3'd2,
    OP_BEEP    = 3'd3,
    OP_DISABLE = 3'd4
  } op_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE    = 3'd0,
    EV_TONE    = 3'd1,
    EV_SILENCE = 3'd2,
    EV_END     = 3'd3,
    EV_STOP    = 3'd4
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CORE_CLOCK = 1'b0,
    CFG_PRESCALER  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [IndexW-1:0] index;
    logic [FreqW-1:0]  frequency;
    logic [DurW-1:0]   duration;
  } tsp_in_t;

  typedef struct packed {
    logic                running;
    logic [ReloadW-1:0]  period_reload;
    logic [CompareW-1:0] duty_compare;
    logic                playing;
    logic [IndexW-1:0]   position;
    logic [EventW-1:0]   event_res;
  } tsp_out_t;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [DurW-1:0]  dur;
  } tsp_entry_t;

endpackage

[hw/rtl/tsp_div.sv]
`timescale 1ns / 1ps

module tsp_div #(
  parameter int unsigned Width = tsp_pkg::ClockW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quotient_o
);

  localparam int unsigned CntW = (Width > 1) ? $clog2(Width) : 1;

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [Width-1:0] num_q;
  logic [Width-1:0] den_q;
  logic [Width-1:0] rem_q;
  logic [Width:0]   rem_sh;
  logic [Width:0]   diff;
  logic             q_bit;

  assign rem_sh = {rem_q, num_q[Width-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign q_bit  = ~diff[Width];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(Width - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= q_bit ? diff[Width-1:0] : rem_sh[Width-1:0];
      num_q <= {num_q[Width-2:0], q_bit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

[hw/rtl/tone_sequence_player.sv]
`timescale 1ns / 1ps
// Tone sequence player: drives the reload and compare values of a PWM timer
// from a table of (frequency, duration) entries.
// Input channel (in_valid_i / in_stall_o) carries one operation per item:
// timer tick, table write, play from index, single beep or disable.
// Output channel (out_valid_o / out_stall_i) returns exactly one result item
// per input item: timer state, sequence state and an event code.
// Configuration writes (cfg_valid_i / cfg_ready_o) set the timer clock and
// prescaler; they are taken in any cycle and should be made while idle.
// Items are handled one at a time; the next item can be taken in the same cycle
// as the previous result appears. Ticks that do not step the sequence, writes,
// disables and ignored ops go straight to the output state; an invalid beep
// passes the check state first, and a step or play that ends or stops reads
// the table before the check. An item that starts a tone or silence goes
// through the table read, the check, the 30-step bit-serial reload divider and
// a finish state; a beep skips the table read.
// The result sits in an output register; while the receiver stalls it holds,
// and the next item is accepted but its result waits until the first is taken.
// Reset clears all control state and the timer values; table contents are
// undefined until written and no clearing pass is made.
module tone_sequence_player #(
  parameter int unsigned TableDepth = tsp_pkg::DefaultTableDepth
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  tsp_pkg::tsp_in_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output tsp_pkg::tsp_out_t                     out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tsp_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [tsp_pkg::CfgDataW-1:0]          cfg_data_i
);

  import tsp_pkg::*;

  localparam int unsigned IdxW   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned NumIdx = 2 ** IndexW;

  state_e state_q, state_d;

  logic [ClockW-1:0]   clock_q;
  logic [PrescW-1:0]   presc_q;
  logic [TickW-1:0]    ticks_q;
  logic                on_q;
  logic                seq_q;
  logic [IdxW-1:0]     ptr_q;
  logic [ReloadW-1:0]  reload_q;
  logic [CompareW-1:0] compare_q;
  event_e              ev_q;
  logic                from_seq_q;
  logic                silence_q;
  logic [FreqW-1:0]    f_q;
  logic [DurW-1:0]     d_q;
  logic [HundW-1:0]    hund_q;
  logic                out_valid_q;
  tsp_out_t            out_q;

  tsp_entry_t          mem_q [TableDepth];
  tsp_entry_t          rdata_q;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;

  logic [IdxW-1:0]     idx_lut [NumIdx];
  logic [IdxW-1:0]     in_idx;
  logic [IdxW-1:0]     ptr_adv;
  logic                accept;
  logic [TickW-1:0]    ticks_dec;
  logic                tick_expire;
  logic                entry_end;
  logic                entry_silence;
  logic                tone_bad;
  logic                div_start;
  logic                div_done;
  logic [ClockW-1:0]   div_quot;
  logic [PrescW-1:0]   presc_eff;
  logic [ToneFreqW-1:0] freq_eff;
  logic [ClockW-1:0]   divisor;
  logic [2*ToneFreqW-1:0] hund_prod;
  logic [ReloadW-1:0]  reload_new;
  logic [TickW:0]      tone_ticks;
  logic [TickW:0]      silence_ticks;
  logic                out_free;

  for (genvar g = 0; g < NumIdx; g++) begin : g_idx_lut
    assign idx_lut[g] = IdxW'(g % TableDepth);
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_idx      = idx_lut[in_data_i.index];
  assign ptr_adv     = (ptr_q == IdxW'(TableDepth - 1)) ? '0 : ptr_q + 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign ticks_dec   = ticks_q - 1'b1;
  assign tick_expire = on_q && (ticks_dec == '0);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign entry_end     = from_seq_q && (f_q == '0) && (d_q == '0);
  assign entry_silence = from_seq_q && (f_q == '0) && (d_q != '0);
  assign tone_bad      = (f_q < FreqMin) || (f_q > FreqMax) || (d_q == '0);

  assign presc_eff = (presc_q == '0) ? PrescW'(1) : presc_q;
  assign freq_eff  = entry_silence ? SilenceFreq : f_q[ToneFreqW-1:0];
  assign divisor   = ClockW'(freq_eff) * ClockW'(presc_eff);
  assign hund_prod = f_q[ToneFreqW-1:0] * HundRecip;

  assign reload_new    = (div_quot == '0) ? '0 : div_quot - 1'b1;
  assign tone_ticks    = (TickW+1)'(hund_q) * (TickW+1)'(d_q) + 1'b1;
  assign silence_ticks = (TickW+1)'(d_q) + 1'b1;

  tsp_div #(
    .Width(ClockW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clock_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.op)
            OP_TICK:  state_d = (tick_expire && seq_q) ? ST_READ : ST_OUT;
            OP_PLAY:  state_d = ST_READ;
            OP_BEEP:  state_d = ST_CHECK;
            default:  state_d = ST_OUT;
          endcase
        end
      end
      ST_READ:  state_d = ST_CHECK;
      ST_CHECK: state_d = (entry_end || (!entry_silence && tone_bad)) ? ST_OUT : ST_DIV;
      ST_DIV:   state_d = div_done ? ST_FIN : ST_DIV;
      ST_FIN:   state_d = ST_OUT;
      ST_OUT:   state_d = out_free ? ST_IDLE : ST_OUT;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start  = (state_q == ST_CHECK) && !entry_end && (entry_silence || !tone_bad);
    rd_en      = 1'b0;
    rd_addr    = ptr_adv;
    if (accept && (in_data_i.op == OP_PLAY)) begin
      rd_en   = 1'b1;
      rd_addr = in_idx;
    end else if (accept && (in_data_i.op == OP_TICK) && tick_expire && seq_q) begin
      rd_en   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_data_i.op == OP_WRITE)) begin
      mem_q[in_idx] <= '{freq: in_data_i.frequency, dur: in_data_i.duration};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      clock_q   <= ClockReset;
      presc_q   <= PrescReset;
      ticks_q   <= '0;
      on_q      <= 1'b0;
      seq_q     <= 1'b0;
      ptr_q     <= '0;
      reload_q  <= '0;
      compare_q <= '0;
      ev_q      <= EV_NONE;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_CORE_CLOCK: clock_q <= cfg_data_i[ClockW-1:0];
          CFG_PRESCALER:  presc_q <= cfg_data_i[PrescW-1:0];
          default:        ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ev_q <= EV_NONE;
            unique case (in_data_i.op)
              OP_TICK: begin
                if (on_q) begin
                  ticks_q <= ticks_dec;
                  if (tick_expire) begin
                    if (seq_q) begin
                      ptr_q <= ptr_adv;
                    end else begin
                      on_q <= 1'b0;
                      ev_q <= EV_STOP;
                    end
                  end
                end
              end
              OP_PLAY: begin
                ptr_q <= in_idx;
                seq_q <= 1'b1;
              end
              OP_DISABLE: begin
                on_q <= 1'b0;
                ev_q <= EV_STOP;
              end
              default: ;
            endcase
          end
        end
        ST_CHECK: begin
          if (entry_end) begin
            on_q  <= 1'b0;
            seq_q <= 1'b0;
            ptr_q <= '0;
            ev_q  <= EV_END;
          end else if (entry_silence) begin
            ev_q <= EV_SILENCE;
          end else if (tone_bad) begin
            on_q <= 1'b0;
            ev_q <= EV_STOP;
          end else begin
            ev_q <= EV_TONE;
          end
        end
        ST_FIN: begin
          reload_q <= reload_new;
          if (silence_q) begin
            compare_q <= '0;
            ticks_q   <= silence_ticks[TickW-1:0];
          end else begin
            compare_q <= reload_new[ReloadW-1:1];
            ticks_q   <= tone_ticks[TickW-1:0];
            on_q      <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      from_seq_q <= (in_data_i.op == OP_TICK);
      f_q        <= in_data_i.frequency;
      d_q        <= in_data_i.duration;
    end else if (state_q == ST_READ) begin
      f_q <= rdata_q.freq;
      d_q <= rdata_q.dur;
    end
    if (state_q == ST_CHECK) begin
      silence_q <= entry_silence;
      hund_q    <= hund_prod[HundShift +: HundW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      out_q.running       <= on_q;
      out_q.period_reload <= reload_q;
      out_q.duty_compare  <= compare_q;
      out_q.playing       <= seq_q;
      out_q.position      <= IndexW'(ptr_q);
      out_q.event_res     <= ev_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

[tb/tb_tone_sequence_player.sv]
`timescale 1ns / 1ps

module tb_tone_sequence_player;
  import tsp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseOps   = 200;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  tsp_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  tsp_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  tone_sequence_player u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // player state as the block should hold it
  logic [FreqW-1:0]    tone_freq_tab [DefaultTableDepth];
  logic [DurW-1:0]     tone_len_tab  [DefaultTableDepth];
  logic [TickW-1:0]    exp_ticks   = '0;
  logic                exp_on      = 1'b0;
  logic                exp_seq     = 1'b0;
  logic [IndexW-1:0]   exp_ptr     = '0;
  logic [ReloadW-1:0]  exp_reload  = '0;
  logic [CompareW-1:0] exp_compare = '0;
  logic [ClockW-1:0]   exp_clock   = ClockReset;
  logic [PrescW-1:0]   exp_presc   = PrescReset;

  tsp_in_t  pending_ops     [$];
  tsp_out_t expected_status [$];
  bit       entry_written   [DefaultTableDepth];

  int  ops_queued   = 0;
  int  items_in     = 0;
  int  results_seen = 0;
  int  fail_count   = 0;
  int  cycle_count  = 0;
  int  burst_left   = 0;
  int  gap_left     = 0;
  int  rx_cycle     = 0;
  logic hold_off;

  function automatic logic [ReloadW-1:0] reload_for_freq(input logic [FreqW-1:0] f);
    longint unsigned fv, pv, quot;
    fv = f;
    pv = exp_presc;
    if (pv == 0) pv = 1;
    if (fv * pv == 0) return '0;
    quot = longint'(exp_clock) / (fv * pv);
    if (quot == 0) return '0;
    return ReloadW'(quot - 1);
  endfunction

  function automatic event_e begin_tone(input logic [FreqW-1:0] f, input logic [DurW-1:0] d);
    int unsigned fi, di;
    fi = f;
    di = d;
    if (f < FreqMin || f > FreqMax || d == '0) begin
      exp_on = 1'b0;
      return EV_STOP;
    end
    exp_ticks   = TickW'((fi / 100) * di + 1);
    exp_reload  = reload_for_freq(f);
    exp_compare = CompareW'(exp_reload >> 1);
    exp_on      = 1'b1;
    return EV_TONE;
  endfunction

  function automatic event_e advance_timer();
    logic [FreqW-1:0] f;
    logic [DurW-1:0]  d;
    int unsigned      di;
    if (!exp_on) return EV_NONE;
    exp_ticks = exp_ticks - 1'b1;
    if (exp_ticks != '0) return EV_NONE;
    if (!exp_seq) begin
      exp_on = 1'b0;
      return EV_STOP;
    end
    exp_ptr = exp_ptr + 1'b1;
    f = tone_freq_tab[exp_ptr];
    d = tone_len_tab[exp_ptr];
    if (f == '0 && d == '0) begin
      exp_on  = 1'b0;
      exp_seq = 1'b0;
      exp_ptr = '0;
      return EV_END;
    end
    if (f == '0) begin
      di          = d;
      exp_reload  = reload_for_freq(16'd100);
      exp_compare = '0;
      exp_ticks   = TickW'(di + 1);
      return EV_SILENCE;
    end
    return begin_tone(f, d);
  endfunction

  function automatic tsp_out_t predict_status(input tsp_in_t it);
    tsp_out_t r;
    event_e   ev;
    ev = EV_NONE;
    case (it.op)
      OP_TICK: ev = advance_timer();
      OP_WRITE: begin
        tone_freq_tab[it.index] = it.frequency;
        tone_len_tab[it.index]  = it.duration;
      end
      OP_PLAY: begin
        exp_ptr = it.index;
        exp_seq = 1'b1;
        ev = begin_tone(tone_freq_tab[it.index], tone_len_tab[it.index]);
      end
      OP_BEEP: ev = begin_tone(it.frequency, it.duration);
      OP_DISABLE: begin
        exp_on = 1'b0;
        ev = EV_STOP;
      end
      default: ;
    endcase
    r.running       = exp_on;
    r.period_reload = exp_reload;
    r.duty_compare  = exp_compare;
    r.playing       = exp_seq;
    r.position      = exp_ptr;
    r.event_res     = ev;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 50) $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  // a written tone or silence must be followed by a written entry, so that no
  // sequence step ever reads an entry that was never written
  task automatic add_op(input logic [OpW-1:0] op, input logic [IndexW-1:0] idx,
                        input logic [FreqW-1:0] f, input logic [DurW-1:0] d);
    tsp_in_t it;
    it.op        = op;
    it.index     = idx;
    it.frequency = f;
    it.duration  = d;
    if (op == OP_WRITE) entry_written[idx] = 1'b1;
    pending_ops.push_back(it);
    ops_queued++;
  endtask

  task automatic add_ticks(input int n);
    repeat (n) add_op(OP_TICK, $urandom, $urandom, $urandom);
  endtask

  task automatic add_short_beep();
    int unsigned f, d;
    f = $urandom_range(100, 999);
    d = $urandom_range(1, 2);
    add_op(OP_BEEP, $urandom, f, d);
    if ($urandom_range(0, 3) == 0) begin
      add_ticks($urandom_range(0, 3));
      add_op(OP_DISABLE, $urandom, $urandom, $urandom);
    end else begin
      add_ticks((f / 100) * d + 1);
    end
  endtask

  task automatic add_sequence();
    int unsigned first, count, k, want;
    int unsigned ef [8];
    int unsigned ed [8];
    first = ($urandom_range(0, 4) == 0) ? $urandom_range(58, 63) : $urandom_range(0, 63);
    count = $urandom_range(1, 6);
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        6, 7: begin
          ef[k] = 0;
          ed[k] = $urandom_range(1, 5);
        end
        8: begin
          ef[k] = $urandom_range(4000, 8000);
          ed[k] = 1;
        end
        9: begin
          case ($urandom_range(0, 2))
            0: begin
              ef[k] = $urandom_range(1, 99);
              ed[k] = $urandom_range(1, 3);
            end
            1: begin
              ef[k] = $urandom_range(8001, 65535);
              ed[k] = $urandom_range(1, 3);
            end
            default: begin
              ef[k] = $urandom_range(100, 8000);
              ed[k] = 0;
            end
          endcase
        end
        default: begin
          ef[k] = $urandom_range(100, 499);
          ed[k] = $urandom_range(1, 3);
        end
      endcase
    end
    add_op(OP_WRITE, first + count, 0, 0);
    for (k = count; k > 0; k--) add_op(OP_WRITE, first + k - 1, ef[k-1], ed[k-1]);
    want = 0;
    for (k = 0; k < count; k++) begin
      if (ef[k] >= 100 && ef[k] <= 8000 && ed[k] != 0) want += (ef[k] / 100) * ed[k] + 1;
      else if (ef[k] == 0 && k > 0) want += ed[k] + 1;
      else break;
    end
    add_op(OP_PLAY, first, $urandom, $urandom);
    for (k = 0; k < want; k++) begin
      add_ticks(1);
      if ($urandom_range(0, 24) == 0) add_short_beep();
      else if ($urandom_range(0, 59) == 0) add_op(OP_DISABLE, $urandom, $urandom, $urandom);
    end
    add_ticks($urandom_range(0, 2));
  endtask

  task automatic add_noise();
    logic [OpW-1:0]    op;
    logic [IndexW-1:0] idx;
    logic [IndexW-1:0] nxt;
    logic [FreqW-1:0]  f;
    logic [DurW-1:0]   d;
    op  = $urandom_range(0, 7);
    idx = $urandom;
    f   = $urandom;
    d   = $urandom;
    nxt = idx + 1'b1;
    if (op == OP_WRITE && !entry_written[nxt]) begin
      f = '0;
      d = '0;
    end
    if (op == OP_PLAY && !(entry_written[idx] && entry_written[nxt])) op = OP_BEEP;
    add_op(op, idx, f, d);
  endtask

  task automatic add_random_chunk();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) begin
      add_sequence();
    end else if (pick < 14) begin
      add_short_beep();
    end else if (pick < 16) begin
      add_op(OP_BEEP, $urandom, $urandom, $urandom);
      add_ticks($urandom_range(0, 4));
      add_op(OP_DISABLE, $urandom, $urandom, $urandom);
    end else begin
      repeat ($urandom_range(1, 3)) add_noise();
    end
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (sel == CFG_CORE_CLOCK) exp_clock = value;
    else exp_presc = value[PrescW-1:0];
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_valid_i || expected_status.size() != 0)
      @(negedge clk_i);
  endtask

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_tone_sequence_player: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin : tx_side
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_status.push_back(predict_status(in_data_i));
        items_in++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          in_data_i  <= pending_ops.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : rx_side
    tsp_out_t want;
    logic     stall_now;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("result %0d arrives with none expected", results_seen));
        end else begin
          want = expected_status.pop_front();
          if (out_data_o.running !== want.running)
            report_mismatch($sformatf("result %0d running %0h, expected %0h",
                                      results_seen, out_data_o.running, want.running));
          if (out_data_o.period_reload !== want.period_reload)
            report_mismatch($sformatf("result %0d period_reload %0d, expected %0d",
                                      results_seen, out_data_o.period_reload,
                                      want.period_reload));
          if (out_data_o.duty_compare !== want.duty_compare)
            report_mismatch($sformatf("result %0d duty_compare %0d, expected %0d",
                                      results_seen, out_data_o.duty_compare,
                                      want.duty_compare));
          if (out_data_o.playing !== want.playing)
            report_mismatch($sformatf("result %0d playing %0h, expected %0h",
                                      results_seen, out_data_o.playing, want.playing));
          if (out_data_o.position !== want.position)
            report_mismatch($sformatf("result %0d position %0d, expected %0d",
                                      results_seen, out_data_o.position, want.position));
          if (out_data_o.event_res !== want.event_res)
            report_mismatch($sformatf("result %0d event_res %0d, expected %0d",
                                      results_seen, out_data_o.event_res, want.event_res));
        end
        results_seen++;
      end
      rx_cycle++;
      case ((rx_cycle >> 9) % 4)
        0: stall_now = 1'b0;
        1: stall_now = ($urandom_range(0, 1) == 0);
        2: stall_now = ((rx_cycle % 7) < 3);
        default: stall_now = ($urandom_range(0, 7) == 0);
      endcase
      out_stall_i <= hold_off || stall_now;
    end
  end

  // hold the receiver off so the block backs up onto its input
  initial begin : long_hold
    hold_off = 1'b0;
    wait (items_in >= 150);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
    wait (items_in >= 900);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    int                  ph;
    int                  goal;
    logic [CfgDataW-1:0] clk_val;
    logic [CfgDataW-1:0] presc_val;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_op(OP_TICK, 6'h3f, 16'hffff, 16'hffff);
    add_op(3'd5, 6'h3f, 16'hffff, 16'hffff);
    add_op(3'd7, 6'h00, 16'h0000, 16'h0000);
    add_op(OP_BEEP, 0, 99, 1);
    add_op(OP_BEEP, 0, 8001, 1);
    add_op(OP_BEEP, 0, 100, 0);
    add_op(OP_BEEP, 0, 100, 1);
    add_ticks(2);
    add_op(OP_BEEP, 0, 8000, 16'hffff);
    add_op(OP_DISABLE, 0, 0, 0);
    add_op(OP_BEEP, 6'h3f, 16'hffff, 16'hffff);
    add_op(OP_WRITE, 2, 0, 0);
    add_op(OP_WRITE, 1, 8000, 0);
    add_op(OP_WRITE, 0, 0, 2);
    add_op(OP_WRITE, 63, 200, 1);
    add_op(OP_PLAY, 63, 0, 0);
    add_ticks(6);
    add_op(OP_BEEP, 0, 100, 1);
    add_ticks(2);

    for (ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: begin
            clk_val   = 30'd1000000000;
            presc_val = 30'd1;
          end
          2: begin
            clk_val   = 30'd1;
            presc_val = 30'd65536;
          end
          3: begin
            clk_val   = 30'd0;
            presc_val = 30'd0;
          end
          4: begin
            clk_val   = 30'h3fffffff;
            presc_val = 30'h1ffff;
          end
          5: begin
            clk_val   = $urandom_range(1, 1000000000);
            presc_val = $urandom_range(1, 65536);
          end
          default: begin
            clk_val   = 30'd64000000;
            presc_val = 30'd64;
          end
        endcase
        write_reg(CFG_CORE_CLOCK, clk_val);
        write_reg(CFG_PRESCALER, presc_val);
        @(negedge clk_i);
      end
      goal = ops_queued + PhaseOps;
      while (ops_queued < goal) add_random_chunk();
    end

    wait_idle();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) $display("tb_tone_sequence_player: PASS");
    else $display("tb_tone_sequence_player: FAIL");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_div.sv
hw/rtl/tone_sequence_player.sv
tb/tb_tone_sequence_player.sv
